// File: src/fbpc_pkg.sv
// Package for the font border pixel cleanup block.
// Holds the register map, reset values and the types shared by the top, front, queue and back modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbpc_pkg;

    localparam int PIX_W      = 32;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd256;
    localparam logic [PIX_W-1:0]    BORDER_RST = 32'hFF00FF00;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BORDER_COLOR = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0]    border_color;
        logic [HEIGHT_W-1:0] image_height;
        logic [WIDTH_W-1:0]  image_width;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             center;
        logic             right_border;
        logic             below_border;
    } item_t;

endpackage

`default_nettype wire

// File: src/fbpc_stream_if.sv
// Stream interfaces for the pixel input channel and the result channel.
// Valid/ready handshake; depends on fbpc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbpc_in_if;
    logic                      valid;
    logic                      ready;
    logic [fbpc_pkg::PIX_W-1:0] pixel;
    logic [fbpc_pkg::PIX_W-1:0] right_pixel;
    logic [fbpc_pkg::PIX_W-1:0] below_pixel;

    modport source (output valid, output pixel, output right_pixel, output below_pixel,
                    input ready);
    modport sink   (input valid, input pixel, input right_pixel, input below_pixel,
                    output ready);
endinterface

interface fbpc_out_if;
    logic                      valid;
    logic                      ready;
    logic [fbpc_pkg::PIX_W-1:0] pixel_out;
    logic                      was_cleared;
    logic                      end_of_frame;

    modport source (output valid, output pixel_out, output was_cleared, output end_of_frame,
                    input ready);
    modport sink   (input valid, input pixel_out, input was_cleared, input end_of_frame,
                    output ready);
endinterface

`default_nettype wire

// File: src/font_border_pixel_cleanup_top.sv
// Flow: an accepted pixel is written into the queue and is then popped into the output register.
// Throughput: one pixel per cycle while the result channel is ready; the line store is read one
// column ahead, with a bypass when the next column is the one being written.
// Reset: rst_n clears counters, flags, queue and output valid at once; the line store
// is not cleared and its read data is ignored in the first row of a frame.
// Depends on fbpc_pkg, the stream interfaces, fbpc_front, fbpc_queue and fbpc_back.
`timescale 1ns / 1ps
`default_nettype none

module font_border_pixel_cleanup_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    fbpc_in_if.sink                              pixels,
    fbpc_out_if.source                           results,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fbpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fbpc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [fbpc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready
);

    logic [fbpc_pkg::WIDTH_W-1:0]  width_reg;
    logic [fbpc_pkg::HEIGHT_W-1:0] height_reg;
    logic [fbpc_pkg::PIX_W-1:0]    color_reg;
    logic                          cfg_write;
    fbpc_pkg::cfg_t                cfg;
    logic                          push, full, pop, not_empty;
    fbpc_pkg::item_t               push_item, pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fbpc_pkg::WIDTH_RST;
            height_reg <= fbpc_pkg::HEIGHT_RST;
            color_reg  <= fbpc_pkg::BORDER_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                fbpc_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[fbpc_pkg::WIDTH_W-1:0];
                fbpc_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[fbpc_pkg::HEIGHT_W-1:0];
                fbpc_pkg::REG_BORDER_COLOR: color_reg  <= pwdata[fbpc_pkg::PIX_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fbpc_pkg::REG_IMAGE_WIDTH:  prdata = fbpc_pkg::APB_DATA_W'(width_reg);
            fbpc_pkg::REG_IMAGE_HEIGHT: prdata = fbpc_pkg::APB_DATA_W'(height_reg);
            fbpc_pkg::REG_BORDER_COLOR: prdata = color_reg;
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.image_width  = width_reg;
        cfg.image_height = height_reg;
        cfg.border_color = color_reg;
    end

    fbpc_front u_front (
        .pixels       (pixels),
        .border_color (color_reg),
        .full         (full),
        .push         (push),
        .push_item    (push_item)
    );

    fbpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    fbpc_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .not_empty (not_empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .results   (results)
    );

endmodule

`default_nettype wire

// File: src/fbpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No contents reset; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbpc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/fbpc_front.sv
// Front end: takes pixel transfers and classifies the three pixels against the
// border colour. Depends on fbpc_pkg and fbpc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module fbpc_front (
    fbpc_in_if.sink                   pixels,
    input  wire logic [fbpc_pkg::PIX_W-1:0] border_color,
    input  wire logic                 full,
    output      logic                 push,
    output      fbpc_pkg::item_t      push_item
);

    assign pixels.ready = !full;
    assign push         = pixels.valid && !full;

    always_comb
    begin
        push_item.pixel        = pixels.pixel;
        push_item.center       = (pixels.pixel == border_color);
        push_item.right_border = (pixels.right_pixel == border_color);
        push_item.below_border = (pixels.below_pixel == border_color);
    end

endmodule

`default_nettype wire

// File: src/fbpc_queue.sv
// Short queue of classified pixels between the front and back ends.
// Depends on fbpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbpc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fbpc_pkg::item_t push_item,
    output      logic            full,
    input  wire logic            pop,
    output      fbpc_pkg::item_t pop_item,
    output      logic            not_empty
);

    fbpc_pkg::item_t                    entry_reg [fbpc_pkg::QUEUE_DEPTH];
    logic [fbpc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [fbpc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [fbpc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_push, do_pop;

    assign full      = (count_reg == fbpc_pkg::QCNT_W'(fbpc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + fbpc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + fbpc_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + fbpc_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - fbpc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/fbpc_back.sv
// Back end: position counters, border run tracking, clear decision, previous-row
// line store and output register. Depends on fbpc_pkg, fbpc_out_if and fbpc_ram.
`timescale 1ns / 1ps
`default_nettype none

module fbpc_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fbpc_pkg::cfg_t  cfg,
    input  wire logic            not_empty,
    input  wire fbpc_pkg::item_t pop_item,
    output      logic            pop,
    fbpc_out_if.source           results
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > fbpc_pkg::WIDTH_W) ? CW + 1 : fbpc_pkg::WIDTH_W;
    localparam int RW   = fbpc_pkg::HEIGHT_W + 1;

    logic [CW-1:0]                   col_reg, col_next;
    logic [fbpc_pkg::HEIGHT_W-1:0]   row_reg, row_next;
    logic                            left_reg, left_next;
    logic                            inside_reg, inside_next;
    logic [1:0]                      run_reg, run_next;
    logic                            fwd_valid_reg, fwd_valid_next;
    logic                            fwd_bit_reg, fwd_bit_next;
    logic                            out_valid_reg, out_valid_next;
    logic [fbpc_pkg::PIX_W-1:0]      pixel_out_reg, pixel_out_next;
    logic                            cleared_reg, cleared_next;
    logic                            eof_reg, eof_next;

    logic [CMPW-1:0]                 w_raw, w_eff;
    logic [fbpc_pkg::HEIGHT_W-1:0]   h_eff;
    logic                            advance;
    logic                            last_col, last_row;
    logic                            right, below, left, up, up_raw;
    logic                            clear, toggle, out_bit;
    logic [1:0]                      run_new;
    logic                            ram_rdata;

    assign advance = not_empty && (!out_valid_reg || results.ready);
    assign pop     = advance;

    always_comb
    begin
        w_raw = CMPW'(cfg.image_width);
        priority if (w_raw == '0)
        begin
            w_eff = CMPW'(1);
        end
        else if (w_raw > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        h_eff = (cfg.image_height == '0) ? fbpc_pkg::HEIGHT_W'(1) : cfg.image_height;
    end

    always_comb
    begin
        last_col = (CMPW'(col_reg) + CMPW'(1)) >= w_eff;
        last_row = (RW'(row_reg) + RW'(1)) >= RW'(h_eff);
        right    = !last_col && pop_item.right_border;
        below    = !last_row && pop_item.below_border;
        left     = (col_reg != '0) && left_reg;
        up_raw   = fwd_valid_reg ? fwd_bit_reg : ram_rdata;
        up       = (row_reg != '0) && up_raw;
        if (inside_reg)
        begin
            clear = pop_item.center && (left || up);
        end
        else
        begin
            clear = pop_item.center && (below || right);
        end

        // saturate at three, drop to zero off the border
        if (!pop_item.center)
        begin
            run_new = 2'd0;
        end
        else if (run_reg == 2'd3)
        begin
            run_new = 2'd3;
        end
        else
        begin
            run_new = run_reg + 2'd1;
        end
        toggle  = pop_item.center && !right && (run_new != 2'd3);
        out_bit = clear ? (cfg.border_color == '0) : pop_item.center;
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        inside_next    = inside_reg;
        run_next       = run_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_bit_next   = fwd_bit_reg;
        out_valid_next = out_valid_reg && !results.ready;
        pixel_out_next = pixel_out_reg;
        cleared_next   = cleared_reg;
        eof_next       = eof_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next    = '0;
                row_next    = last_row ? '0 : row_reg + fbpc_pkg::HEIGHT_W'(1);
                inside_next = 1'b0;
                run_next    = 2'd0;
            end
            else
            begin
                col_next    = col_reg + CW'(1);
                inside_next = inside_reg ^ toggle;
                run_next    = run_new;
            end
            left_next      = out_bit;
            fwd_valid_next = (col_next == col_reg);
            fwd_bit_next   = out_bit;
            out_valid_next = 1'b1;
            pixel_out_next = clear ? '0 : pop_item.pixel;
            cleared_next   = clear;
            eof_next       = last_col && last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            run_reg       <= 2'd0;
            fwd_valid_reg <= 1'b0;
            fwd_bit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            inside_reg    <= inside_next;
            run_reg       <= run_next;
            fwd_valid_reg <= fwd_valid_next;
            fwd_bit_reg   <= fwd_bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
        cleared_reg   <= cleared_next;
        eof_reg       <= eof_next;
    end

    fbpc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (advance),
        .waddr (col_reg),
        .wdata (out_bit),
        .re    (advance),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    assign results.valid        = out_valid_reg;
    assign results.pixel_out    = pixel_out_reg;
    assign results.was_cleared  = cleared_reg;
    assign results.end_of_frame = eof_reg;

endmodule

`default_nettype wire

// File: src/fbpc_checker.sv
// Port-level checks on the cleanup block, attached to the top level by bind.
// Depends on fbpc_pkg and font_border_pixel_cleanup_top.
`timescale 1ns / 1ps
`default_nettype none

module fbpc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [fbpc_pkg::PIX_W-1:0]      pixel_out,
    input wire logic                            was_cleared,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [fbpc_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [fbpc_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [fbpc_pkg::APB_DATA_W-1:0] prdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(was_cleared))
        else $error("result changed while stalled");

    a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_cleared |-> pixel_out == '0)
        else $error("cleared pixel is not zero");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_height_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == fbpc_pkg::REG_IMAGE_HEIGHT)
        ##1 (psel && !pwrite && paddr[3:2] == fbpc_pkg::REG_IMAGE_HEIGHT)
        |-> prdata[fbpc_pkg::HEIGHT_W-1:0] == $past(pwdata[fbpc_pkg::HEIGHT_W-1:0]))
        else $error("height register readback mismatch");

endmodule

bind font_border_pixel_cleanup_top fbpc_checker u_fbpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .pixel_out   (results.pixel_out),
    .was_cleared (results.was_cleared),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

`default_nettype wire
